// File: rtl/process_state_queue_manager_top_defines.svh
// ----------------------------------------------------------------------------
// Process state queue manager: assertion macros
// Shared property forms for the block's checkers.
// ----------------------------------------------------------------------------
`ifndef PROCESS_STATE_QUEUE_MANAGER_TOP_DEFINES_SVH
`define PROCESS_STATE_QUEUE_MANAGER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSQM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PSQM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/psqm_pkg.sv
// ----------------------------------------------------------------------------
// Process state queue manager package
// Item types, command codes and status codes.
// ----------------------------------------------------------------------------
package psqm_pkg;

  localparam int OP_W      = 3;
  localparam int IN_ID_W   = 16;
  localparam int ST_W      = 2;
  localparam int CNT_OUT_W = 5;
  localparam int HEAD_W    = 16;

  localparam logic [OP_W-1:0] OP_ADD       = 3'd0;
  localparam logic [OP_W-1:0] OP_DISPATCH  = 3'd1;
  localparam logic [OP_W-1:0] OP_TIMEOUT   = 3'd2;
  localparam logic [OP_W-1:0] OP_EVT_WAIT  = 3'd3;
  localparam logic [OP_W-1:0] OP_EVT_OCCUR = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
  localparam logic [ST_W-1:0] ST_UNMET  = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
  localparam logic [ST_W-1:0] ST_BAD_OP = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [IN_ID_W-1:0] process_id;
  } psqm_in_t;

  typedef struct packed {
    logic [ST_W-1:0]      status;
    logic [CNT_OUT_W-1:0] ready_count;
    logic [CNT_OUT_W-1:0] running_count;
    logic [CNT_OUT_W-1:0] blocked_count;
    logic [HEAD_W-1:0]    ready_head;
    logic [HEAD_W-1:0]    running_head;
    logic [HEAD_W-1:0]    blocked_head;
  } psqm_out_t;

  // Per-queue action for one command: at most one pop and one push.
  typedef struct packed {
    logic pop;
    logic push;
  } psqm_qop_t;

endpackage

// File: rtl/psqm_queue.sv
// ----------------------------------------------------------------------------
// Process state queue manager: one circular queue
// Keeps the store, front index, size, a head register and a prefetched
// second entry so that one pop and one push retire together.
// ----------------------------------------------------------------------------
module psqm_queue #(
  parameter int CAPACITY = 16,
  parameter int ID_BITS  = 16,
  parameter int IDX_W    = $clog2(CAPACITY),
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  psqm_pkg::psqm_qop_t  op,
  input  logic [ID_BITS-1:0]   push_data,
  output logic [CNT_W-1:0]     size,
  output logic [ID_BITS-1:0]   head,
  output logic [CNT_W-1:0]     size_nxt,
  output logic [ID_BITS-1:0]   head_shown
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  logic [ID_BITS-1:0] mem [CAPACITY];
  logic [IDX_W-1:0]   front_r, front_nxt;
  logic [CNT_W-1:0]   size_r, size_nxt_w;
  logic [ID_BITS-1:0] head_r, head_nxt;
  logic [ID_BITS-1:0] next_r;
  logic [CNT_W:0]     tail_sum;
  logic [IDX_W-1:0]   tail, front_inc, raddr;
  logic               do_pop, do_push;

  assign do_pop  = en & op.pop;
  assign do_push = en & op.push;

  // Tail slot is the same whether the pop comes before or after the push.
  assign tail_sum = (CNT_W+1)'(front_r) + (CNT_W+1)'(size_r);
  assign tail = (tail_sum >= (CNT_W+1)'(CAPACITY)) ?
                IDX_W'(tail_sum - (CNT_W+1)'(CAPACITY)) : IDX_W'(tail_sum);

  assign front_inc = (front_r == LAST_IDX) ? '0 : front_r + IDX_W'(1);
  assign front_nxt = do_pop ? front_inc : front_r;
  assign raddr     = (front_nxt == LAST_IDX) ? '0 : front_nxt + IDX_W'(1);

  assign size_nxt_w = size_r + CNT_W'(do_push) - CNT_W'(do_pop);

  always_comb begin
    if (do_pop) begin
      head_nxt = (size_r >= CNT_W'(2)) ? next_r : push_data;
    end else begin
      head_nxt = (size_r != '0) ? head_r : push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      size_r  <= '0;
    end else begin
      front_r <= front_nxt;
      size_r  <= size_nxt_w;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
  end

  // Store write at the tail; prefetch the entry behind the next front.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= push_data;
    end
    if (do_push && (tail == raddr)) begin
      next_r <= push_data;
    end else begin
      next_r <= mem[raddr];
    end
  end

  assign size       = size_r;
  assign head       = head_r;
  assign size_nxt   = size_nxt_w;
  assign head_shown = (size_nxt_w != '0) ? head_nxt : '0;

endmodule

// File: rtl/psqm_ctrl.sv
// ----------------------------------------------------------------------------
// Process state queue manager: command decode
// Turns one command and the queue views into per-queue pop/push actions.
// ----------------------------------------------------------------------------
module psqm_ctrl #(
  parameter int CAPACITY = 16,
  parameter int ID_BITS  = 16,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  psqm_pkg::psqm_in_t             cmd,
  input  logic [CNT_W-1:0]               rdy_size,
  input  logic [CNT_W-1:0]               run_size,
  input  logic [CNT_W-1:0]               blk_size,
  input  logic [ID_BITS-1:0]             rdy_head,
  input  logic [ID_BITS-1:0]             run_head,
  input  logic [ID_BITS-1:0]             blk_head,
  output psqm_pkg::psqm_qop_t            rdy_op,
  output psqm_pkg::psqm_qop_t            run_op,
  output psqm_pkg::psqm_qop_t            blk_op,
  output logic [ID_BITS-1:0]             rdy_data,
  output logic [ID_BITS-1:0]             run_data,
  output logic [ID_BITS-1:0]             blk_data,
  output logic [psqm_pkg::ST_W-1:0]      status
);

  logic [CNT_W+1:0] total;
  logic             rdy_empty, run_empty, blk_empty;

  assign total = (CNT_W+2)'(rdy_size) + (CNT_W+2)'(run_size) + (CNT_W+2)'(blk_size);
  assign rdy_empty = (rdy_size == '0);
  assign run_empty = (run_size == '0);
  assign blk_empty = (blk_size == '0);

  always_comb begin
    rdy_op   = '0;
    run_op   = '0;
    blk_op   = '0;
    status   = psqm_pkg::ST_DONE;
    rdy_data = ID_BITS'(cmd.process_id);
    run_data = rdy_head;
    blk_data = run_head;
    case (cmd.opcode)
      psqm_pkg::OP_ADD: begin
        if (total >= (CNT_W+2)'(CAPACITY)) begin
          status = psqm_pkg::ST_FULL;
        end else begin
          rdy_op.push = 1'b1;
        end
      end
      psqm_pkg::OP_DISPATCH: begin
        if (rdy_empty) begin
          status = psqm_pkg::ST_UNMET;
        end else begin
          rdy_op.pop  = 1'b1;
          run_op.push = 1'b1;
        end
      end
      psqm_pkg::OP_TIMEOUT: begin
        if (run_empty || rdy_empty) begin
          status = psqm_pkg::ST_UNMET;
        end else begin
          // Running head to ready tail, then old ready head to running.
          rdy_op.push = 1'b1;
          rdy_op.pop  = 1'b1;
          rdy_data    = run_head;
          run_op.pop  = 1'b1;
          run_op.push = 1'b1;
        end
      end
      psqm_pkg::OP_EVT_WAIT: begin
        if (run_empty) begin
          status = psqm_pkg::ST_UNMET;
        end else begin
          run_op.pop  = 1'b1;
          blk_op.push = 1'b1;
          if (!rdy_empty) begin
            rdy_op.pop  = 1'b1;
            run_op.push = 1'b1;
          end
        end
      end
      psqm_pkg::OP_EVT_OCCUR: begin
        if (blk_empty) begin
          status = psqm_pkg::ST_UNMET;
        end else begin
          blk_op.pop = 1'b1;
          // Empty ready: the woken id goes straight to running, bypassing ready.
          if (rdy_empty) begin
            run_op.push = 1'b1;
            run_data    = blk_head;
          end else begin
            rdy_op.push = 1'b1;
            rdy_data    = blk_head;
          end
        end
      end
      default: begin
        status = psqm_pkg::ST_BAD_OP;
      end
    endcase
  end

endmodule

// File: rtl/process_state_queue_manager_top.sv
// ----------------------------------------------------------------------------
// Process state queue manager top level
// Ready, running and blocked FIFOs of process ids driven by one command
// per cycle while busy is low.
// ----------------------------------------------------------------------------
// Commands enter on start while busy is low; a new command is accepted
// every clock. A command is captured in an input register at the
// accepting edge, decoded and applied to the three queues in the following
// cycle, and its result (status, three counts, three heads after the
// command) appears on out_data with out_valid high for exactly one cycle,
// driven from the result register. The receiver cannot stall the block, so
// every result must be taken in the cycle it is shown. Busy is high only in
// the cycle after a reset edge. Each queue retires at most one pop and one
// push per command, using a head register and a prefetched second entry
// read from its store through a registered port. The stores hold no valid
// bits and need no clearing pass; an entry is read only after it has been
// written.
// ----------------------------------------------------------------------------
module process_state_queue_manager_top #(
  parameter int CAPACITY = 16,
  parameter int ID_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  psqm_pkg::psqm_in_t  in_data,
  output logic                out_valid,
  output psqm_pkg::psqm_out_t out_data
);

  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CntOutW  = psqm_pkg::CNT_OUT_W;
  localparam int HeadW    = psqm_pkg::HEAD_W;

  // Input register
  psqm_pkg::psqm_in_t cmd_r;
  logic               cmd_vld_r;
  logic               busy_r;
  logic               accept;

  // Result register
  psqm_pkg::psqm_out_t out_r, out_nxt;
  logic                out_vld_r;

  // Decode to queue actions
  psqm_pkg::psqm_qop_t          rdy_op, run_op, blk_op;
  logic [ID_BITS-1:0]           rdy_data, run_data, blk_data;
  logic [psqm_pkg::ST_W-1:0]    status;

  // Queue views
  logic [CNT_W-1:0]   rdy_size, run_size, blk_size;
  logic [CNT_W-1:0]   rdy_size_nxt, run_size_nxt, blk_size_nxt;
  logic [ID_BITS-1:0] rdy_head, run_head, blk_head;
  logic [ID_BITS-1:0] rdy_shown, run_shown, blk_shown;

  assign accept = start & ~busy_r;

  // Hold busy for one cycle out of reset; otherwise take a command each clock.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      cmd_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      busy_r    <= 1'b0;
      cmd_vld_r <= accept;
      out_vld_r <= cmd_vld_r;
    end
  end

  // Capture the command payload; no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_data;
    end
  end

  psqm_ctrl #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .cmd      (cmd_r),
    .rdy_size (rdy_size),
    .run_size (run_size),
    .blk_size (blk_size),
    .rdy_head (rdy_head),
    .run_head (run_head),
    .blk_head (blk_head),
    .rdy_op   (rdy_op),
    .run_op   (run_op),
    .blk_op   (blk_op),
    .rdy_data (rdy_data),
    .run_data (run_data),
    .blk_data (blk_data),
    .status   (status)
  );

  psqm_queue #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_ready_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (cmd_vld_r),
    .op         (rdy_op),
    .push_data  (rdy_data),
    .size       (rdy_size),
    .head       (rdy_head),
    .size_nxt   (rdy_size_nxt),
    .head_shown (rdy_shown)
  );

  psqm_queue #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_running_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (cmd_vld_r),
    .op         (run_op),
    .push_data  (run_data),
    .size       (run_size),
    .head       (run_head),
    .size_nxt   (run_size_nxt),
    .head_shown (run_shown)
  );

  psqm_queue #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_blocked_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (cmd_vld_r),
    .op         (blk_op),
    .push_data  (blk_data),
    .size       (blk_size),
    .head       (blk_head),
    .size_nxt   (blk_size_nxt),
    .head_shown (blk_shown)
  );

  // Report the state left behind by the command, clipped to field widths.
  always_comb begin
    out_nxt.status        = status;
    out_nxt.ready_count   = CntOutW'(rdy_size_nxt);
    out_nxt.running_count = CntOutW'(run_size_nxt);
    out_nxt.blocked_count = CntOutW'(blk_size_nxt);
    out_nxt.ready_head    = HeadW'(rdy_shown);
    out_nxt.running_head  = HeadW'(run_shown);
    out_nxt.blocked_head  = HeadW'(blk_shown);
  end

  always_ff @(posedge clk) begin
    if (cmd_vld_r) begin
      out_r <= out_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// File: rtl/psqm_checker.sv
// ----------------------------------------------------------------------------
// Process state queue manager checker
// Port-level properties of the top level, attached by bind.
// ----------------------------------------------------------------------------
`include "process_state_queue_manager_top_defines.svh"

module psqm_port_checker #(
  parameter int CAPACITY = 16
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input psqm_pkg::psqm_out_t out_data
);

  logic [6:0] total;
  logic       cap_fits;

  assign total = 7'(out_data.ready_count) + 7'(out_data.running_count) +
                 7'(out_data.blocked_count);
  assign cap_fits = (CAPACITY <= 31);

  // Every accepted item yields exactly one result, through the input and result registers.
  `PSQM_ASSERT_IMPL(a_result_latency, clk, rst_n, $past(rst_n) && $past(rst_n, 2), out_valid == $past(start && !busy, 2), "result strobe does not follow accepted item")

  // Busy drops right after reset and stays low.
  `PSQM_ASSERT_NEXT(a_busy_low, clk, rst_n, 1'b1, !busy, "busy high outside reset")

  // Queues never hold more than the capacity in total.
  `PSQM_ASSERT_IMPL(a_total_bound, clk, rst_n, out_valid && cap_fits, total <= 7'(CAPACITY), "queue total exceeds capacity")

  // A full refusal means the queues are at capacity.
  `PSQM_ASSERT_IMPL(a_full_total, clk, rst_n, out_valid && cap_fits && (out_data.status == psqm_pkg::ST_FULL), total == 7'(CAPACITY), "full status below capacity")

  // A command that did nothing leaves the counts as the previous result showed.
  `PSQM_ASSERT_IMPL(a_noop_stable, clk, rst_n, out_valid && $past(out_valid) && (out_data.status != psqm_pkg::ST_DONE), $stable(total) && $stable(out_data.ready_count) && $stable(out_data.running_count), "counts moved on a refused command")

endmodule

bind process_state_queue_manager_top psqm_port_checker #(
  .CAPACITY (CAPACITY)
) u_psqm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// File: test/psqm_checker.sv
// ----------------------------------------------------------------------------
// Process state queue manager scoreboard
// Watches the command and result channels, tracks the three process queues
// and checks every result field against the tracked state.
// ----------------------------------------------------------------------------
module psqm_checker #(
  parameter int CAPACITY = 16,
  parameter int ID_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  psqm_pkg::psqm_in_t  in_data,
  input  logic                out_valid,
  input  psqm_pkg::psqm_out_t out_data,
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [psqm_pkg::HEAD_W-1:0] ID_MASK =
    psqm_pkg::HEAD_W'((64'd1 << ID_BITS) - 64'd1);

  logic [psqm_pkg::HEAD_W-1:0] ready_ids[$];
  logic [psqm_pkg::HEAD_W-1:0] running_ids[$];
  logic [psqm_pkg::HEAD_W-1:0] blocked_ids[$];
  psqm_pkg::psqm_out_t         expected_status[$];
  int                          mismatches = 0;

  // Apply one command to the tracked queues and return the status and
  // queue snapshot it should produce.
  function automatic psqm_pkg::psqm_out_t apply_command(psqm_pkg::psqm_in_t cmd);
    psqm_pkg::psqm_out_t res;
    logic                ready_was_empty;
    res        = '0;
    res.status = psqm_pkg::ST_DONE;
    case (cmd.opcode)
      psqm_pkg::OP_ADD: begin
        if (ready_ids.size() + running_ids.size() + blocked_ids.size() >= CAPACITY)
          res.status = psqm_pkg::ST_FULL;
        else
          ready_ids.push_back(cmd.process_id & ID_MASK);
      end
      psqm_pkg::OP_DISPATCH: begin
        if (ready_ids.size() == 0)
          res.status = psqm_pkg::ST_UNMET;
        else
          running_ids.push_back(ready_ids.pop_front());
      end
      psqm_pkg::OP_TIMEOUT: begin
        if (running_ids.size() == 0 || ready_ids.size() == 0) begin
          res.status = psqm_pkg::ST_UNMET;
        end else begin
          ready_ids.push_back(running_ids.pop_front());
          running_ids.push_back(ready_ids.pop_front());
        end
      end
      psqm_pkg::OP_EVT_WAIT: begin
        if (running_ids.size() == 0) begin
          res.status = psqm_pkg::ST_UNMET;
        end else begin
          blocked_ids.push_back(running_ids.pop_front());
          if (ready_ids.size() != 0)
            running_ids.push_back(ready_ids.pop_front());
        end
      end
      psqm_pkg::OP_EVT_OCCUR: begin
        if (blocked_ids.size() == 0) begin
          res.status = psqm_pkg::ST_UNMET;
        end else begin
          ready_was_empty = (ready_ids.size() == 0);
          ready_ids.push_back(blocked_ids.pop_front());
          if (ready_was_empty)
            running_ids.push_back(ready_ids.pop_front());
        end
      end
      default: res.status = psqm_pkg::ST_BAD_OP;
    endcase
    res.ready_count   = psqm_pkg::CNT_OUT_W'(ready_ids.size());
    res.running_count = psqm_pkg::CNT_OUT_W'(running_ids.size());
    res.blocked_count = psqm_pkg::CNT_OUT_W'(blocked_ids.size());
    res.ready_head    = (ready_ids.size() == 0) ? '0 : ready_ids[0];
    res.running_head  = (running_ids.size() == 0) ? '0 : running_ids[0];
    res.blocked_head  = (blocked_ids.size() == 0) ? '0 : blocked_ids[0];
    return res;
  endfunction

  task automatic check_field(input string name, input logic [psqm_pkg::HEAD_W-1:0] want,
                             input logic [psqm_pkg::HEAD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    psqm_pkg::psqm_out_t want;
    if (!rst_n) begin
      ready_ids.delete();
      running_ids.delete();
      blocked_ids.delete();
      expected_status.delete();
    end else begin
      // Compare a shown result against the oldest outstanding command.
      if (out_valid) begin
        if (expected_status.size() == 0) begin
          $display("%0t: result with no command outstanding, actual %h", $realtime,
                   out_data);
          mismatches++;
        end else begin
          want = expected_status.pop_front();
          check_field("status",        psqm_pkg::HEAD_W'(want.status),
                      psqm_pkg::HEAD_W'(out_data.status));
          check_field("ready_count",   psqm_pkg::HEAD_W'(want.ready_count),
                      psqm_pkg::HEAD_W'(out_data.ready_count));
          check_field("running_count", psqm_pkg::HEAD_W'(want.running_count),
                      psqm_pkg::HEAD_W'(out_data.running_count));
          check_field("blocked_count", psqm_pkg::HEAD_W'(want.blocked_count),
                      psqm_pkg::HEAD_W'(out_data.blocked_count));
          check_field("ready_head",    want.ready_head,             out_data.ready_head);
          check_field("running_head",  want.running_head,           out_data.running_head);
          check_field("blocked_head",  want.blocked_head,           out_data.blocked_head);
        end
      end
      if (start && !busy)
        expected_status.push_back(apply_command(in_data));
    end
    fail_count <= mismatches;
    pending    <= expected_status.size();
  end

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// Process state queue manager testbench
// Drives directed and randomly weighted command streams with random gaps
// into the block; a scoreboard beside it checks every result.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY      = 16;
  localparam int ID_BITS       = 16;
  localparam int RANDOM_ITEMS  = 590;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 4;

  // Opcodes the block must reject.
  localparam logic [psqm_pkg::OP_W-1:0] OP_BAD_5 = 3'd5;
  localparam logic [psqm_pkg::OP_W-1:0] OP_BAD_6 = 3'd6;
  localparam logic [psqm_pkg::OP_W-1:0] OP_BAD_7 = 3'd7;

  // Weighting of the random command mix.
  typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                start     = 1'b0;
  psqm_pkg::psqm_in_t  in_data   = '0;
  logic                busy;
  logic                out_valid;
  psqm_pkg::psqm_out_t out_data;
  int                  fail_count;
  int                  pending;
  int                  stall_cycles = 0;
  logic                no_gaps = 1'b0;

  process_state_queue_manager_top #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  psqm_checker #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Present one command and hold it until the block takes it. Start stays
  // high on return so a back-to-back item needs no second assignment.
  task automatic issue(input logic [psqm_pkg::OP_W-1:0] op,
                       input logic [psqm_pkg::IN_ID_W-1:0] id);
    in_data <= psqm_pkg::psqm_in_t'{opcode: op, process_id: id};
    start   <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // Drop start for a random number of cycles: mostly none or short, a few long.
  task automatic idle_gap();
    int roll;
    int cycles;
    roll   = $urandom_range(0, 99);
    cycles = 0;
    if (!no_gaps) begin
      if (roll >= 90)
        cycles = $urandom_range(8, 40);
      else if (roll >= 50)
        cycles = $urandom_range(1, 3);
    end
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Bias ids toward the all-zero and all-one corners.
  function automatic logic [psqm_pkg::IN_ID_W-1:0] pick_id();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0)
      return '0;
    if (roll == 1)
      return '1;
    return psqm_pkg::IN_ID_W'($urandom_range(0, 65535));
  endfunction

  // Choose an opcode by the current weighting; a few invalid ones always.
  function automatic logic [psqm_pkg::OP_W-1:0] pick_op(input mix_t mix);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      case ($urandom_range(0, 2))
        0:       return OP_BAD_5;
        1:       return OP_BAD_6;
        default: return OP_BAD_7;
      endcase
    end
    case (mix)
      MIX_FILL: begin
        if (roll < 60) return psqm_pkg::OP_ADD;
        if (roll < 75) return psqm_pkg::OP_DISPATCH;
        if (roll < 85) return psqm_pkg::OP_TIMEOUT;
        if (roll < 93) return psqm_pkg::OP_EVT_WAIT;
        return psqm_pkg::OP_EVT_OCCUR;
      end
      MIX_DRAIN: begin
        if (roll < 15) return psqm_pkg::OP_ADD;
        if (roll < 35) return psqm_pkg::OP_DISPATCH;
        if (roll < 55) return psqm_pkg::OP_TIMEOUT;
        if (roll < 80) return psqm_pkg::OP_EVT_WAIT;
        return psqm_pkg::OP_EVT_OCCUR;
      end
      default: begin
        if (roll < 30) return psqm_pkg::OP_ADD;
        if (roll < 48) return psqm_pkg::OP_DISPATCH;
        if (roll < 65) return psqm_pkg::OP_TIMEOUT;
        if (roll < 83) return psqm_pkg::OP_EVT_WAIT;
        return psqm_pkg::OP_EVT_OCCUR;
      end
    endcase
  endfunction

  // End the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int   valid_items;
    int   chunk_left;
    mix_t mix;
    logic [psqm_pkg::OP_W-1:0] op;

    // Hold reset from the start, then release it once for the whole run.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every command but add on empty queues, then an invalid opcode.
    issue(psqm_pkg::OP_DISPATCH, '0);
    issue(psqm_pkg::OP_TIMEOUT, '0);
    issue(psqm_pkg::OP_EVT_WAIT, '0);
    issue(psqm_pkg::OP_EVT_OCCUR, '0);
    issue(OP_BAD_5, '1);
    // Id corners, and a timeout refused with only ready non-empty.
    issue(psqm_pkg::OP_ADD, '0);
    idle_gap();
    issue(psqm_pkg::OP_ADD, '1);
    issue(psqm_pkg::OP_TIMEOUT, '0);
    // Move heads around: dispatch, rotate, block with and without a refill.
    issue(psqm_pkg::OP_DISPATCH, '0);
    issue(psqm_pkg::OP_TIMEOUT, '0);
    idle_gap();
    issue(psqm_pkg::OP_EVT_WAIT, '0);
    issue(psqm_pkg::OP_EVT_WAIT, '0);
    // Wake into an empty ready queue, which dispatches right away.
    issue(psqm_pkg::OP_EVT_OCCUR, '0);
    // Block again, then wake while ready holds an id: no dispatch.
    issue(psqm_pkg::OP_EVT_WAIT, '0);
    issue(psqm_pkg::OP_ADD, 16'h5a5a);
    issue(psqm_pkg::OP_EVT_OCCUR, '0);
    // Fill to capacity, then one add that must be refused.
    repeat (CAPACITY - 3) begin
      issue(psqm_pkg::OP_ADD, pick_id());
      idle_gap();
    end
    issue(psqm_pkg::OP_ADD, 16'ha5a5);

    // Random: chunks of commands with a shared weighting so the queues
    // swing between full and empty. Invalid opcodes do not count.
    valid_items = 0;
    chunk_left  = 0;
    mix         = MIX_EVEN;
    while (valid_items < RANDOM_ITEMS) begin
      if (chunk_left == 0) begin
        chunk_left = $urandom_range(20, 60);
        mix        = mix_t'($urandom_range(0, 2));
        no_gaps    = ($urandom_range(0, 3) == 0);
      end
      op = pick_op(mix);
      issue(op, pick_id());
      if (op <= psqm_pkg::OP_EVT_OCCUR)
        valid_items++;
      chunk_left--;
      idle_gap();
    end

    // Stop sending, wait for every outstanding result, then idle to catch any
    // stray strobe.
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/psqm_pkg.sv
rtl/psqm_queue.sv
rtl/psqm_ctrl.sv
rtl/process_state_queue_manager_top.sv
rtl/psqm_checker.sv
test/psqm_checker.sv
test/testbench.sv
